// ===== rtl/bucketed_key_membership_table_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the bucketed key membership table
// Shared property wrappers, clocked on i_clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef BUCKETED_KEY_MEMBERSHIP_TABLE_MACROS_SVH
`define BUCKETED_KEY_MEMBERSHIP_TABLE_MACROS_SVH

// same-cycle implication
`define BKM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BKM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bkm_pkg.sv =====
// ---------------------------------------------------------------------------
// bkm_pkg
// Sizes, types and the write request shared by the table's memories.
// ---------------------------------------------------------------------------
package bkm_pkg;

    localparam int CHAR_BITS    = 4;
    localparam int BUCKET_DEPTH = 8;

    localparam int KEY_HIGH_W  = 32;
    localparam int KEY_LOW_W   = 64;
    localparam int KEY_W       = KEY_HIGH_W + KEY_LOW_W;
    localparam int BUCKET_W    = 2 * CHAR_BITS;
    localparam int NUM_BUCKETS = 1 << BUCKET_W;
    localparam int FILL_W      = $clog2(BUCKET_DEPTH + 1);
    localparam int SLOT_W      = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;

    // key byte 8 / byte 9 positions inside key_low
    localparam int BYTE8_LSB = 24;
    localparam int BYTE9_LSB = 16;

    // operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    typedef logic [KEY_W-1:0]                     t_key;
    typedef logic [BUCKET_DEPTH-1:0][KEY_W-1:0]   t_key_row;
    typedef logic [BUCKET_W-1:0]                  t_bucket;
    typedef logic [FILL_W-1:0]                    t_fill;
    typedef logic [SLOT_W-1:0]                    t_slot;

    // one insert: key into a slot, new fill count for the bucket
    typedef struct packed {
        logic    we;
        t_bucket bucket;
        t_slot   slot;
        t_key    key;
        t_fill   fill;
    } t_wr_req;

endpackage

// ===== rtl/bucketed_key_membership_table.sv =====
// ---------------------------------------------------------------------------
// bucketed_key_membership_table
// Set of 96-bit keys in buckets chosen by the low nibbles of key bytes 8 and 9: insert appends
// to the bucket unless full, lookup compares against every filled slot.
// ---------------------------------------------------------------------------
//  channel  dir  tdata                                  tuser
//  s_axis   in   [31:0] key_high, [95:32] key_low       [0] func
//  m_axis   out  [0] found, [1] full_res, [7:2] zero    -
//
//  Each item is read, then compared: the accept cycle reads the bucket's key row
//  and fill count, then ST_LOOK compares all slots and writes back.
//  The write lands before the next item's read, so no forwarding is needed.
//  Synchronous active-low reset clears the fill valid bits at once.
//  A result waiting in the output register holds the compare cycle.
// ---------------------------------------------------------------------------
`include "bucketed_key_membership_table_macros.svh"

module bucketed_key_membership_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // [31:0] key_high, [95:32] key_low
    input  logic [0:0]  s_axis_tuser,   // [0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] found, [1] full_res, [7:2] zero
);
    import bkm_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_LOOK
    } t_state;

    t_state   r_state;
    logic     r_func;
    t_key     r_key;
    t_bucket  r_bucket;
    logic     r_m_valid;
    logic     r_found;
    logic     r_full;

    logic     s_accept;
    logic     out_free;
    logic     look_done;
    t_bucket  in_bucket;
    t_key     in_key;
    t_key_row rd_row;
    t_fill    rd_fill;
    logic [BUCKET_DEPTH-1:0] hit;
    logic     bucket_full;
    logic     found_c;
    logic     full_c;
    t_wr_req  wr;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;
    assign look_done     = (r_state == ST_LOOK) && out_free;

    // key packed as {key_low, key_high}; bucket from bytes 8 and 9
    assign in_key    = s_axis_tdata;
    assign in_bucket = {s_axis_tdata[KEY_HIGH_W + BYTE8_LSB +: CHAR_BITS],
                        s_axis_tdata[KEY_HIGH_W + BYTE9_LSB +: CHAR_BITS]};

    bkm_key_ram u_key_ram (
        .i_clk       (i_clk),
        .i_rd_en     (s_accept),
        .i_rd_bucket (in_bucket),
        .i_wr        (wr),
        .o_rd_row    (rd_row)
    );

    bkm_fill_tbl u_fill_tbl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (s_accept),
        .i_rd_bucket (in_bucket),
        .i_wr        (wr),
        .o_rd_fill   (rd_fill)
    );

    // compare every filled slot of the row
    always_comb begin
        for (int s = 0; s < BUCKET_DEPTH; s++) begin
            hit[s] = (FILL_W'(s) < rd_fill) && (rd_row[s] == r_key);
        end
    end

    assign bucket_full = (rd_fill >= FILL_W'(BUCKET_DEPTH));
    assign found_c     = (r_func == FUNC_LOOKUP) && (|hit);
    assign full_c      = (r_func == FUNC_INSERT) && bucket_full;

    // write-back of an insert that fits
    always_comb begin
        wr.we     = look_done && (r_func == FUNC_INSERT) && !bucket_full;
        wr.bucket = r_bucket;
        wr.slot   = rd_fill[SLOT_W-1:0];
        wr.key    = r_key;
        wr.fill   = rd_fill + FILL_W'(1);
    end

    // sequencer, item capture and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (s_accept) begin
                        r_state <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (look_done) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
        if (s_accept) begin
            r_func   <= s_axis_tuser[0];
            r_key    <= in_key;
            r_bucket <= in_bucket;
        end
        if (look_done) begin
            r_found <= found_c;
            r_full  <= full_c;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {6'b0, r_full, r_found};

    // checks on the sequencing and result encoding
    `BKM_ASSERT_NEXT(a_accept_blocks, s_accept, !s_axis_tready, "item accepted during compare")
    `BKM_ASSERT_SAME(a_excl_flags, r_m_valid, !(r_found && r_full), "found and full both set")
    `BKM_ASSERT_SAME(a_wr_fits, wr.we, rd_fill < FILL_W'(BUCKET_DEPTH), "insert past bucket depth")
    `BKM_ASSERT_NEXT(a_done_valid, look_done, r_m_valid && s_axis_tready, "result not presented")

endmodule

// ===== rtl/bkm_key_ram.sv =====
// ---------------------------------------------------------------------------
// bkm_key_ram
// Key store: one row per bucket, one slot per key, slot-wise write,
// whole-row synchronous read into an output register.
// ---------------------------------------------------------------------------
module bkm_key_ram (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  bkm_pkg::t_bucket  i_rd_bucket,
    input  bkm_pkg::t_wr_req  i_wr,
    output bkm_pkg::t_key_row o_rd_row
);
    import bkm_pkg::*;

    t_key_row r_mem [NUM_BUCKETS];
    t_key_row r_rd_row;

    // slot write and registered row read
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.bucket][i_wr.slot] <= i_wr.key;
        end
        if (i_rd_en) begin
            r_rd_row <= r_mem[i_rd_bucket];
        end
    end

    assign o_rd_row = r_rd_row;

endmodule

// ===== rtl/bkm_fill_tbl.sv =====
// ---------------------------------------------------------------------------
// bkm_fill_tbl
// Fill count per bucket in a synchronous memory; a valid bit per bucket
// makes unwritten counts read as zero right after reset.
// ---------------------------------------------------------------------------
module bkm_fill_tbl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  bkm_pkg::t_bucket i_rd_bucket,
    input  bkm_pkg::t_wr_req i_wr,
    output bkm_pkg::t_fill   o_rd_fill
);
    import bkm_pkg::*;

    t_fill r_mem [NUM_BUCKETS];
    logic  r_vld [NUM_BUCKETS];
    t_fill r_rd_fill;

    // count memory: write on insert, registered read
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.bucket] <= i_wr.fill;
        end
        if (i_rd_en) begin
            r_rd_fill <= r_vld[i_rd_bucket] ? r_mem[i_rd_bucket] : '0;
        end
    end

    // valid bits, cleared together by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BUCKETS; b++) begin
                r_vld[b] <= 1'b0;
            end
        end else if (i_wr.we) begin
            r_vld[i_wr.bucket] <= 1'b1;
        end
    end

    assign o_rd_fill = r_rd_fill;

endmodule

// ===== bench/bucketed_key_membership_table_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// bucketed_key_membership_table_tb
// Drives insert and lookup items into the key table through the input
// stream and checks every result against a bucket-level predictor of the
// table. Directed items fill a bucket to overflow and probe near misses;
// random items favor a few crowded buckets so drops and hits are common.
// Both stream sides idle at random.
// ---------------------------------------------------------------------------
module bucketed_key_membership_table_tb;

    import bkm_pkg::*;

    localparam int RANDOM_OPS  = 1150;
    localparam int CYCLE_LIMIT = 250000;
    localparam int DRAIN_WAIT  = 20;
    localparam int NUM_HOT     = 4;
    localparam int POOL_MAX    = 256;

    typedef struct {
        logic func;
        t_key key;      // {key_low, key_high}, same layout as tdata
    } t_table_op;

    typedef struct {
        logic found;
        logic full_res;
    } t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;     // [31:0] key_high, [95:32] key_low
    logic [0:0]  s_axis_tuser = '0;     // [0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // [0] found, [1] full_res, [7:2] zero

    bucketed_key_membership_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predicted table contents
    t_key     key_store [NUM_BUCKETS][BUCKET_DEPTH];
    int       bucket_count [NUM_BUCKETS];
    t_verdict expected_verdicts[$];

    t_table_op pending_ops[$];
    t_key      known_keys[$];
    t_bucket   hot_buckets[NUM_HOT];

    int ops_total;
    int ops_accepted;
    int results_seen;
    int mismatch_count;
    int insert_count;
    int dropped_count;
    int lookup_count;
    int hit_count;
    int burst_left = 8;
    int gap_left;
    int cycle_count;

    function automatic t_bucket bucket_of_key(t_key key);
        return {key[KEY_HIGH_W+BYTE8_LSB +: CHAR_BITS], key[KEY_HIGH_W+BYTE9_LSB +: CHAR_BITS]};
    endfunction

    // random key that lands in the given bucket
    function automatic t_key key_in_bucket(t_bucket bucket);
        t_key key;
        key = {$urandom, $urandom, $urandom};
        key[KEY_HIGH_W+BYTE8_LSB +: CHAR_BITS] = bucket[BUCKET_W-1 -: CHAR_BITS];
        key[KEY_HIGH_W+BYTE9_LSB +: CHAR_BITS] = bucket[CHAR_BITS-1:0];
        return key;
    endfunction

    function automatic t_bucket pick_bucket();
        if ($urandom_range(0, 1) == 0)
            return hot_buckets[$urandom_range(0, NUM_HOT-1)];
        return t_bucket'($urandom_range(0, NUM_BUCKETS-1));
    endfunction

    function automatic void queue_op(logic func, t_key key);
        t_table_op op;
        op.func = func;
        op.key  = key;
        pending_ops.insert(pending_ops.size(), op);
        if (func == FUNC_INSERT) begin
            known_keys.insert(known_keys.size(), key);
            if (known_keys.size() > POOL_MAX)
                void'(known_keys.pop_front());
        end
    endfunction

    // table update and expected result for one accepted item
    function automatic void apply_table_op(t_table_op op);
        t_bucket  bucket;
        t_verdict verdict;
        bucket = bucket_of_key(op.key);
        verdict.found = 1'b0;
        verdict.full_res = 1'b0;
        if (op.func == FUNC_INSERT) begin
            insert_count++;
            if (bucket_count[bucket] >= BUCKET_DEPTH) begin
                verdict.full_res = 1'b1;
                dropped_count++;
            end else begin
                key_store[bucket][bucket_count[bucket]] = op.key;
                bucket_count[bucket]++;
            end
        end else begin
            lookup_count++;
            for (int slot = 0; slot < bucket_count[bucket]; slot++)
                if (key_store[bucket][slot] == op.key)
                    verdict.found = 1'b1;
            if (verdict.found)
                hit_count++;
        end
        expected_verdicts.insert(expected_verdicts.size(), verdict);
    endfunction

    // stimulus: directed items, then random items
    initial begin
        t_key zero_key;
        t_key ones_key;
        t_key dropped_key;
        t_key last_key;
        t_key key;
        int   pick;

        zero_key = '0;
        ones_key = '1;
        hot_buckets[0] = '0;
        hot_buckets[1] = '1;
        for (int h = 2; h < NUM_HOT; h++)
            hot_buckets[h] = t_bucket'($urandom_range(0, NUM_BUCKETS-1));

        // extremes, exact-match lookups, single-bit near misses
        queue_op(FUNC_INSERT, zero_key);
        queue_op(FUNC_INSERT, ones_key);
        queue_op(FUNC_LOOKUP, zero_key);
        queue_op(FUNC_LOOKUP, ones_key);
        queue_op(FUNC_LOOKUP, zero_key ^ (t_key'(1) << (KEY_W-1)));
        queue_op(FUNC_LOOKUP, zero_key ^ t_key'(1));
        queue_op(FUNC_LOOKUP, ones_key ^ (t_key'(1) << KEY_HIGH_W));

        // fill bucket zero, one duplicate among the entries
        queue_op(FUNC_INSERT, zero_key);
        for (int i = 2; i < BUCKET_DEPTH; i++) begin
            last_key = key_in_bucket('0);
            queue_op(FUNC_INSERT, last_key);
        end
        // overflow: dropped key must not be found afterwards
        dropped_key = key_in_bucket('0);
        queue_op(FUNC_INSERT, dropped_key);
        queue_op(FUNC_LOOKUP, dropped_key);
        queue_op(FUNC_LOOKUP, last_key);
        queue_op(FUNC_INSERT, zero_key);
        // lookup into an empty bucket
        queue_op(FUNC_LOOKUP, key_in_bucket(t_bucket'(NUM_BUCKETS/2 + 3)));

        // random mix: crowded buckets, repeats, near misses, fresh keys
        for (int n = 0; n < RANDOM_OPS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                if ($urandom_range(0, 9) < 3)
                    key = known_keys[$urandom_range(0, known_keys.size()-1)];
                else
                    key = key_in_bucket(pick_bucket());
                queue_op(FUNC_INSERT, key);
            end else begin
                pick = $urandom_range(0, 99);
                key = known_keys[$urandom_range(0, known_keys.size()-1)];
                if (pick < 20)
                    key = key ^ (t_key'(1) << $urandom_range(0, KEY_W-1));
                else if (pick < 45)
                    key = key_in_bucket(pick_bucket());
                queue_op(FUNC_LOOKUP, key);
            end
        end
        ops_total = pending_ops.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (ops_accepted < ops_total || expected_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("ran %0d inserts (%0d dropped on full buckets) and %0d lookups (%0d hits)",
                 insert_count, dropped_count, lookup_count, hit_count);
        $display("checked %0d results, %0d mismatches", results_seen, mismatch_count);
        if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
            $display("bucketed_key_membership_table verification clean");
        end else begin
            $display("bucketed_key_membership_table verification failed");
        end
        $finish;
    end

    // input driver: bursts of items separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_table_op(pending_ops.pop_front());
                ops_accepted++;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // item still offered, hold it
            end else if (gap_left > 0 || pending_ops.size() == 0) begin
                if (gap_left > 0)
                    gap_left--;
                s_axis_tvalid <= 1'b0;
            end else begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_ops[0].key;
                s_axis_tuser  <= pending_ops[0].func;
            end
        end
    end

    // output back-pressure: steps through always-ready, random, mostly-stalled and periodic modes
    always @(posedge i_clk) begin
        case ((cycle_count / 256) % 4)
            0: begin
                m_axis_tready <= 1'b1;
            end
            1: begin
                m_axis_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_axis_tready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                m_axis_tready <= cycle_count[2];
            end
        endcase
    end

    // result monitor
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (expected_verdicts.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result %0d arrived with nothing expected: found=%0b full_res=%0b",
                             results_seen, m_axis_tdata[0], m_axis_tdata[1]);
            end else begin
                want = expected_verdicts.pop_front();
                if (m_axis_tdata[0] !== want.found || m_axis_tdata[1] !== want.full_res) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"result %0d: expected found=%0b full_res=%0b, ",
                                  "got found=%0b full_res=%0b"},
                                 results_seen, want.found, want.full_res,
                                 m_axis_tdata[0], m_axis_tdata[1]);
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timed out after %0d cycles, %0d of %0d items accepted",
                     cycle_count, ops_accepted, ops_total);
            $display("bucketed_key_membership_table verification failed");
            $finish;
        end
    end

endmodule
